// File: design/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define RHPL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds in a cycle, consequent must hold in the next cycle
`define RHPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/rhpl_pkg.sv
// types and constants of the rtp header payload locator
`default_nettype none
package rhpl_pkg;

  localparam int unsigned HDR_FIXED = 12;
  localparam logic [7:0] BIT_PADDING = 8'h20;
  localparam logic [7:0] MASK_CC = 8'h0f;
  localparam logic [7:0] BIT_EXT = 8'h10;
  localparam logic [1:0] RTP_VERSION = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_BAD_PAD   = 3'd3,
    ST_SHORT_CC  = 3'd4,
    ST_SHORT_EXT = 3'd5,
    ST_BAD_EXT   = 3'd6,
    ST_TOO_LONG  = 3'd7
  } status_e;

  // header facts of one finished packet, handed from front to back
  typedef struct packed {
    logic       ovf;
    logic [7:0] hb;
    logic [15:0] ext;
    logic [7:0] pad;
  } rec_t;

endpackage
`default_nettype wire

// File: design/rhpl_front.sv
// byte intake: counts bytes, captures header fields, emits one record per packet
`default_nettype none
module rhpl_front #(
  parameter int unsigned MaxBytes = 2048,
  localparam int unsigned CW = $clog2(MaxBytes + 1),
  localparam int unsigned SW = CW + 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire logic           ready_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           last_i,
  output rhpl_pkg::rec_t      rec_o,
  output logic [SW-1:0]       size_o,
  output logic                push_o
);

  localparam int unsigned XW = CW + 7;
  localparam logic [CW-1:0] MAX_C = CW'(MaxBytes);

  logic [CW-1:0] count_q, count_d;
  logic [7:0]    hb_q, hb_d;
  logic [15:0]   ext_q, ext_d;
  logic          ovf_q, ovf_d;
  logic          hit, in_rng;
  logic [6:0]    ext_pos;
  logic [XW-1:0] idx_x;
  logic [7:0]    hb_n;
  logic [15:0]   ext_n;
  logic          ovf_n;

  always_comb begin
    hit     = valid_i & ready_i;
    in_rng  = count_q < MAX_C;
    ovf_n   = ovf_q | ~in_rng;
    hb_n    = (count_q == '0) ? byte_i : hb_q;
    ext_pos = 7'd14 + {1'b0, hb_n[3:0], 2'b00};
    idx_x   = XW'(count_q);
    ext_n   = ext_q;
    if (in_rng) begin
      if (idx_x == XW'(ext_pos)) begin
        ext_n[15:8] = byte_i;
      end else if (idx_x == XW'(ext_pos) + XW'(1)) begin
        ext_n[7:0] = byte_i;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    hb_d    = hb_q;
    ext_d   = ext_q;
    ovf_d   = ovf_q;
    if (hit) begin
      if (last_i) begin
        count_d = '0;
        hb_d    = '0;
        ext_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        hb_d  = hb_n;
        ext_d = ext_n;
        ovf_d = ovf_n;
        if (!ovf_n) begin
          count_d = count_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hb_q    <= '0;
      ext_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      hb_q    <= hb_d;
      ext_q   <= ext_d;
      ovf_q   <= ovf_d;
    end
  end

  assign push_o    = hit & last_i;
  assign size_o    = SW'(count_q) + SW'(1);
  assign rec_o.ovf = ovf_n;
  assign rec_o.hb  = hb_n;
  assign rec_o.ext = ext_n;
  assign rec_o.pad = byte_i;

endmodule
`default_nettype wire

// File: design/rhpl_queue.sv
// two-entry fifo between intake and evaluation
`default_nettype none
module rhpl_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       lvl_q;
  logic             do_push, do_pop;

  assign full_o  = lvl_q == 2'd2;
  assign empty_o = lvl_q == 2'd0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      lvl_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      lvl_q <= lvl_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: design/rhpl_back.sv
// header checks and payload offset/length, with a registered result stage
`default_nettype none
module rhpl_back #(
  parameter int unsigned SW = 13
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rhpl_pkg::rec_t  rec_i,
  input  wire logic [SW-1:0]   size_i,
  input  wire logic            avail_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output rhpl_pkg::status_e    status_o,
  output logic [11:0]          offset_o,
  output logic [11:0]          length_o
);

  localparam int unsigned AW = ((SW > 18) ? SW : 18) + 2;

  logic [AW-1:0] sz, sz2, pad, off, off_x, ext4, len;
  logic          has_pad, has_ext;
  rhpl_pkg::status_e st;
  logic          valid_q;
  rhpl_pkg::status_e st_q;
  logic [11:0]   off_q, len_q;

  always_comb begin
    sz      = AW'(size_i);
    pad     = AW'(rec_i.pad);
    has_pad = |(rec_i.hb & rhpl_pkg::BIT_PADDING);
    has_ext = |(rec_i.hb & rhpl_pkg::BIT_EXT);
    sz2     = has_pad ? sz - pad : sz;
    off     = AW'(rhpl_pkg::HDR_FIXED) + AW'({rec_i.hb & rhpl_pkg::MASK_CC, 2'b00});
    ext4    = AW'({rec_i.ext, 2'b00});
    off_x   = has_ext ? off + AW'(4) + ext4 : off;
    len     = sz2 - off_x;
    if (rec_i.ovf) begin
      st = rhpl_pkg::ST_TOO_LONG;
    end else if (sz < AW'(rhpl_pkg::HDR_FIXED)) begin
      st = rhpl_pkg::ST_SHORT;
    end else if (rec_i.hb[7:6] != rhpl_pkg::RTP_VERSION) begin
      st = rhpl_pkg::ST_BAD_VER;
    end else if (has_pad && (pad + AW'(rhpl_pkg::HDR_FIXED) > sz)) begin
      st = rhpl_pkg::ST_BAD_PAD;
    end else if (sz2 < off) begin
      st = rhpl_pkg::ST_SHORT_CC;
    end else if (has_ext && (sz2 < off + AW'(4))) begin
      st = rhpl_pkg::ST_SHORT_EXT;
    end else if (has_ext && (sz2 < off_x)) begin
      st = rhpl_pkg::ST_BAD_EXT;
    end else begin
      st = rhpl_pkg::ST_OK;
    end
  end

  assign pop_o = avail_i & (~valid_q | ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (~valid_q | ready_i) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      st_q  <= st;
      off_q <= (st == rhpl_pkg::ST_OK) ? off_x[11:0] : 12'd0;
      len_q <= (st == rhpl_pkg::ST_OK) ? len[11:0] : 12'd0;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = st_q;
  assign offset_o = off_q;
  assign length_o = len_q;

endmodule
`default_nettype wire

// File: design/rtp_header_payload_locator_core.sv
// top level of the rtp header payload locator
// usage:
//   s_axis carries the packet one byte per transfer, header first; tlast
//   marks the final byte. bytes are taken while the record queue has room,
//   and packets may follow each other with no gap between them.
//   m_axis gives one transfer per packet: status, payload offset and
//   payload length (offset and length are zero on an error status).
// result path: the final byte's record is written into the queue, then
//   evaluated into the result register that drives m_axis_tvalid; a held
//   result or earlier queued packets can delay that evaluation.
// throughput: one byte per cycle while the queue has room; one packet per
//   cycle in the evaluator while m_axis_tready is high, so short packets keep pace.
// stall: while m_axis_tready is low the result holds; up to two further
//   finished packets wait in the queue, after that s_axis_tready drops.
// reset: rst_ni clears the byte count, captured header fields, queue and
//   result valid; the block is ready for a new packet right after reset.
// packets longer than MaxBytes report status too long on their last byte.
`default_nettype none
`include "assert_macros.svh"
module rtp_header_payload_locator_core #(
  parameter int unsigned MaxBytes = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] pkt_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [2:0] status, [14:3] payload_offset,
                                             // [26:15] payload_length, rest zero
);

  localparam int unsigned CW = $clog2(MaxBytes + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned QW = $bits(rhpl_pkg::rec_t) + SW;

  rhpl_pkg::rec_t    f_rec, q_rec;
  logic [SW-1:0]     f_size, q_size;
  logic              f_push, q_full, q_empty, b_pop;
  rhpl_pkg::status_e st;
  logic [11:0]       off, len;
  logic              res_ok, off_ok;

  // intake stalls only when the record queue has no room
  assign s_axis_tready_o = ~q_full;

  rhpl_front #(.MaxBytes(MaxBytes)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_i (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .rec_o   (f_rec),
    .size_o  (f_size),
    .push_o  (f_push)
  );

  rhpl_queue #(.Width(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_size, f_rec}),
    .pop_i   (b_pop),
    .data_o  ({q_size, q_rec}),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rhpl_back #(.SW(SW)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rec_i    (q_rec),
    .size_i   (q_size),
    .avail_i  (~q_empty),
    .pop_o    (b_pop),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .status_o (st),
    .offset_o (off),
    .length_o (len)
  );

  assign m_axis_tdata_o = {5'd0, len, off, st};

  assign res_ok = st == rhpl_pkg::ST_OK;
  assign off_ok = off >= 12'd12 && off[1:0] == 2'b00;

  // error results carry no offset and no length
  `RHPL_ASSERT_SAME(a_err_zero, clk_i, rst_ni, m_axis_tvalid_o && !res_ok, off == '0 && len == '0)
  // a good payload starts past the fixed header on a word boundary
  `RHPL_ASSERT_SAME(a_ok_off, clk_i, rst_ni, m_axis_tvalid_o && res_ok, off_ok)
  // a final byte taken into an empty queue is waiting there on the next cycle
  `RHPL_ASSERT_NEXT(a_q_fill, clk_i, rst_ni, f_push && q_empty && !m_axis_tvalid_o, !q_empty)

endmodule
`default_nettype wire
